// ----- design/brb_pkg.sv -----
`timescale 1ns / 1ps
package brb_pkg;

  localparam int unsigned DEPTH_DEF       = 16;
  localparam int unsigned CHUNK_BYTES_DEF = 8;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned ST_W     = 2;
  localparam int unsigned WDATA_W  = 64;
  localparam int unsigned WLEN_W   = 12;
  localparam int unsigned RIDX_W   = 8;
  localparam int unsigned PASS_W   = 16;
  localparam int unsigned LEN_W    = 4;
  localparam int unsigned AMT_W    = 12;
  localparam int unsigned CLIM_W   = 4;
  localparam int unsigned IN_DATA_W  = 104;
  localparam int unsigned OUT_DATA_W = 104;

  localparam logic [CLIM_W-1:0] CLIM_RESET = 4'd8;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 3'd0,
    CMD_READ  = 3'd1,
    CMD_AVAIL = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_GET   = 3'd4
  } brb_cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_ERR   = 2'd1,
    ST_EMPTY = 2'd2
  } brb_status_e;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECODE = 5'b00010,
    S_READ   = 5'b00100,
    S_SUM    = 5'b01000,
    S_DONE   = 5'b10000
  } brb_state_e;

endpackage

// ----- design/broadcast_ring_buffer.sv -----
`timescale 1ns / 1ps
// Write, reset indices, get indices, a failed read and an available query with nothing
//   readable go from decode straight to done; a read that returns an entry passes the read
//   state, an available query that sums N entries the sum state (one length read per cycle,
//   then a drain). One word in work at a time; the next word is accepted once the result
//   is loaded and the FSM is back in idle, later while m_axis_tready_i holds a result.
// Reset (rst_ni low, async): write slot and lap to zero, chunk limit to 8, all entry valid
//   bits cleared so unwritten entries read as zero data of length CHUNK_BYTES; no clear pass.
module broadcast_ring_buffer
  import brb_pkg::*;
#(
  parameter int unsigned DEPTH       = DEPTH_DEF,
  parameter int unsigned CHUNK_BYTES = CHUNK_BYTES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CLIM_W-1:0]     cfg_data_i,      // chunk_limit
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,  // write_data, write_length, reader_index,
                                                 // reader_pass, zero pad
  input  logic [CMD_W-1:0]      s_axis_tuser_i,  // command
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,  // read_data, read_length, next_index,
                                                 // next_pass, amount
  output logic [ST_W-1:0]       m_axis_tuser_o   // status
);

  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned DATA_W = 8 * CHUNK_BYTES;
  localparam logic [RIDX_W:0]    DEPTH_V = (RIDX_W + 1)'(DEPTH);
  localparam logic [IDX_W-1:0]   LAST_SLOT = IDX_W'(DEPTH - 1);
  localparam logic [LEN_W-1:0]   FULL_LEN = LEN_W'(CHUNK_BYTES);

  brb_state_e state_q, state_d;

  logic [CLIM_W-1:0] chunk_limit_q;
  logic [IDX_W-1:0]  write_slot_q, write_slot_d;
  logic [PASS_W-1:0] write_lap_q, write_lap_d;

  brb_cmd_e          cmd_q, cmd_d;
  logic [WDATA_W-1:0] wdata_q, wdata_d;
  logic [WLEN_W-1:0] wlen_q, wlen_d;
  logic [RIDX_W-1:0] ridx_q, ridx_d;
  logic [PASS_W-1:0] rpass_q, rpass_d;

  brb_status_e       res_status_q, res_status_d;
  logic [WDATA_W-1:0] res_data_q, res_data_d;
  logic [LEN_W-1:0]  res_len_q, res_len_d;
  logic [RIDX_W-1:0] res_idx_q, res_idx_d;
  logic [PASS_W-1:0] res_pass_q, res_pass_d;
  logic [AMT_W-1:0]  res_amount_q, res_amount_d;

  logic [IDX_W-1:0]  ptr_q, ptr_d;
  logic [AMT_W-1:0]  acc_q, acc_d;
  logic              rd_pend_q, rd_pend_d;

  logic                  m_valid_q, m_valid_d;
  logic [OUT_DATA_W-1:0] m_data_q, m_data_d;
  logic [ST_W-1:0]       m_user_q, m_user_d;

  logic [DATA_W-1:0] chunk_mem [DEPTH];
  logic [LEN_W-1:0]  len_mem [DEPTH];
  logic [DEPTH-1:0]  vld_q;
  logic [DATA_W-1:0] rd_chunk_q;
  logic [LEN_W-1:0]  rd_len_q;
  logic              rd_vld_q;

  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_raddr;
  logic [DATA_W-1:0] mem_wdata, wmask;
  logic [LEN_W-1:0]  lim_eff, wclip;
  logic [DATA_W-1:0] rd_chunk_eff;
  logic [LEN_W-1:0]  rd_len_eff;

  logic              s_fire;
  logic [PASS_W-1:0] prev_lap;
  logic [RIDX_W-1:0] ws_ext;
  logic              ridx_ok, lap_same, lap_prev, rd_ok, rd_empty, walk_ok;
  logic [IDX_W-1:0]  ptr_next;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  always_comb begin
    if (chunk_limit_q == '0) begin
      lim_eff = LEN_W'(1);
    end else if (chunk_limit_q > FULL_LEN) begin
      lim_eff = FULL_LEN;
    end else begin
      lim_eff = chunk_limit_q;
    end
  end

  assign wclip = (wlen_q > WLEN_W'(lim_eff)) ? lim_eff : wlen_q[LEN_W-1:0];

  always_comb begin
    for (int b = 0; b < CHUNK_BYTES; b++) begin
      wmask[b*8 +: 8] = (LEN_W'(b) < wclip) ? 8'hFF : 8'h00;
    end
  end

  assign mem_wdata    = wdata_q[DATA_W-1:0] & wmask;
  assign rd_chunk_eff = rd_vld_q ? rd_chunk_q : '0;
  assign rd_len_eff   = rd_vld_q ? rd_len_q : FULL_LEN;

  assign prev_lap = write_lap_q - PASS_W'(1);
  assign ws_ext   = RIDX_W'(write_slot_q);
  assign ridx_ok  = {1'b0, ridx_q} < DEPTH_V;
  assign lap_same = (rpass_q == write_lap_q);
  assign lap_prev = (rpass_q == prev_lap);
  assign walk_ok  = ridx_ok && ((lap_same && (ridx_q < ws_ext)) ||
                                (!lap_same && lap_prev && (ridx_q > ws_ext)));
  assign rd_ok    = walk_ok;
  assign rd_empty = ridx_ok && lap_same && (ridx_q == ws_ext);
  assign ptr_next = (ptr_q == LAST_SLOT) ? '0 : ptr_q + IDX_W'(1);

  always_comb begin
    state_d      = state_q;
    write_slot_d = write_slot_q;
    write_lap_d  = write_lap_q;
    cmd_d        = cmd_q;
    wdata_d      = wdata_q;
    wlen_d       = wlen_q;
    ridx_d       = ridx_q;
    rpass_d      = rpass_q;
    res_status_d = res_status_q;
    res_data_d   = res_data_q;
    res_len_d    = res_len_q;
    res_idx_d    = res_idx_q;
    res_pass_d   = res_pass_q;
    res_amount_d = res_amount_q;
    ptr_d        = ptr_q;
    acc_d        = acc_q;
    rd_pend_d    = 1'b0;
    m_valid_d    = m_valid_q;
    m_data_d     = m_data_q;
    m_user_d     = m_user_q;
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_raddr    = ridx_q[IDX_W-1:0];

    if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (s_fire) begin
          cmd_d   = brb_cmd_e'(s_axis_tuser_i);
          wdata_d = s_axis_tdata_i[63:0];
          wlen_d  = s_axis_tdata_i[75:64];
          ridx_d  = s_axis_tdata_i[83:76];
          rpass_d = s_axis_tdata_i[99:84];
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        res_status_d = ST_ERR;
        res_data_d   = '0;
        res_len_d    = '0;
        res_idx_d    = '0;
        res_pass_d   = '0;
        res_amount_d = '0;
        state_d      = S_DONE;
        unique case (cmd_q)
          CMD_WRITE: begin
            if (wlen_q != '0) begin
              mem_we       = 1'b1;
              res_status_d = ST_OK;
              res_amount_d = wlen_q;
              if (write_slot_q == LAST_SLOT) begin
                write_slot_d = '0;
                write_lap_d  = write_lap_q + PASS_W'(1);
              end else begin
                write_slot_d = write_slot_q + IDX_W'(1);
              end
            end
          end
          CMD_READ: begin
            res_idx_d  = ridx_q;
            res_pass_d = rpass_q;
            if (rd_ok) begin
              mem_re       = 1'b1;
              res_status_d = ST_OK;
              state_d      = S_READ;
              if (ridx_q == RIDX_W'(DEPTH - 1)) begin
                res_idx_d  = '0;
                res_pass_d = rpass_q + PASS_W'(1);
              end else begin
                res_idx_d  = ridx_q + RIDX_W'(1);
              end
            end else if (rd_empty) begin
              res_status_d = ST_EMPTY;
            end
          end
          CMD_AVAIL: begin
            if (ridx_ok) begin
              res_status_d = ST_OK;
              if (walk_ok) begin
                ptr_d   = ridx_q[IDX_W-1:0];
                acc_d   = '0;
                state_d = S_SUM;
              end
            end
          end
          CMD_CLEAR: begin
            write_slot_d = '0;
            write_lap_d  = '0;
            res_status_d = ST_OK;
          end
          CMD_GET: begin
            res_idx_d    = ws_ext;
            res_pass_d   = write_lap_q;
            res_status_d = ST_OK;
          end
          default: begin
            res_status_d = ST_ERR;
          end
        endcase
      end
      S_READ: begin
        res_data_d = WDATA_W'(rd_chunk_eff);
        res_len_d  = rd_len_eff;
        state_d    = S_DONE;
      end
      S_SUM: begin
        if (rd_pend_q) begin
          acc_d = acc_q + AMT_W'(rd_len_eff);
        end
        if (ptr_q != write_slot_q) begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q;
          ptr_d     = ptr_next;
          rd_pend_d = 1'b1;
        end else if (!rd_pend_q) begin
          res_amount_d = acc_q;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d = 1'b1;
          m_data_d  = {res_amount_q, res_pass_q, res_idx_q, res_len_q, res_data_q};
          m_user_d  = res_status_q;
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      chunk_limit_q <= CLIM_RESET;
      write_slot_q  <= '0;
      write_lap_q   <= '0;
      rd_pend_q     <= 1'b0;
      m_valid_q     <= 1'b0;
      vld_q         <= '0;
      rd_vld_q      <= 1'b0;
    end else begin
      state_q      <= state_d;
      write_slot_q <= write_slot_d;
      write_lap_q  <= write_lap_d;
      rd_pend_q    <= rd_pend_d;
      m_valid_q    <= m_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        chunk_limit_q <= cfg_data_i;
      end
      if (mem_we) begin
        vld_q[write_slot_q] <= 1'b1;
      end
      if (mem_re) begin
        rd_vld_q <= vld_q[mem_raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    wdata_q      <= wdata_d;
    wlen_q       <= wlen_d;
    ridx_q       <= ridx_d;
    rpass_q      <= rpass_d;
    res_status_q <= res_status_d;
    res_data_q   <= res_data_d;
    res_len_q    <= res_len_d;
    res_idx_q    <= res_idx_d;
    res_pass_q   <= res_pass_d;
    res_amount_q <= res_amount_d;
    ptr_q        <= ptr_d;
    acc_q        <= acc_d;
    m_data_q     <= m_data_d;
    m_user_q     <= m_user_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      chunk_mem[write_slot_q] <= mem_wdata;
      len_mem[write_slot_q]   <= wclip;
    end
    if (mem_re) begin
      rd_chunk_q <= chunk_mem[mem_raddr];
      rd_len_q   <= len_mem[mem_raddr];
    end
  end

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, RIDX_W'(write_slot_q)} < DEPTH_V)
    else $error("write slot out of range");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready_o)
    else $error("ready while a word is in work");

  a_write_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> (write_slot_q != $past(write_slot_q)))
    else $error("write did not advance slot");

  a_sum_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM) |-> (acc_q <= AMT_W'(DEPTH * CHUNK_BYTES)))
    else $error("available sum over ring capacity");

endmodule
